// ===== rtl/core/zsbf_pkg.sv =====
// constants shared by the zlib stored-block framer
// header bytes, block limits, adler modulus and result slot codes
// no dependencies
package zsbf_pkg;

  localparam int unsigned LENGTH_BITS = 24;
  localparam int unsigned CFG_BITS    = 24;
  localparam int unsigned BLOCK_BITS  = 17;
  localparam int unsigned MAX_BLOCK   = 65535;

  localparam logic [LENGTH_BITS-1:0] MAX_BLOCK_LEN = LENGTH_BITS'(MAX_BLOCK);
  localparam logic [16:0]            ADLER_MOD     = 17'd65521;
  localparam logic [7:0]             ZLIB_CMF      = 8'h78;
  localparam logic [7:0]             ZLIB_FLG      = 8'h01;

  localparam int unsigned NUM_SLOTS = 12;
  localparam int unsigned SLOT_BITS = 4;

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  localparam slot_t SLOT_CMF     = 4'd0;
  localparam slot_t SLOT_FLG     = 4'd1;
  localparam slot_t SLOT_BFINAL  = 4'd2;
  localparam slot_t SLOT_LEN_LO  = 4'd3;
  localparam slot_t SLOT_LEN_HI  = 4'd4;
  localparam slot_t SLOT_NLEN_LO = 4'd5;
  localparam slot_t SLOT_NLEN_HI = 4'd6;
  localparam slot_t SLOT_DATA    = 4'd7;
  localparam slot_t SLOT_SH_HI   = 4'd8;
  localparam slot_t SLOT_SH_LO   = 4'd9;
  localparam slot_t SLOT_SL_HI   = 4'd10;
  localparam slot_t SLOT_SL_LO   = 4'd11;

endpackage

// ===== rtl/core/zlib_stored_block_framer_core.sv =====
// zlib stream framer with stored deflate blocks and adler-32 trailer
// depends on zsbf_pkg
//
//   channel   role            fields
//   s_*       payload in      tdata[7:0] data_byte
//   m_*       stream out      tdata[7:0] out_byte, tlast run_last, tuser stream_end
//   cfg_*     register write  data[23:0] total_length
//
// one input register feeds the framing logic, which fills a twelve-slot result
// register with a mask of the bytes to send; one byte leaves per cycle while m_tready is high.
// a plain payload byte is sent alone, so bytes stream at one per cycle while m_tready is high;
// an input that opens a stream or block, or closes a stream, sends up to 12
// bytes from the result register and input stalls behind it.
// rst is synchronous and clears the sums, counters and both stages.
module zlib_stored_block_framer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // data_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // out_byte
  output logic                          m_tlast,   // run_last
  output logic                          m_tuser,   // stream_end
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [zsbf_pkg::CFG_BITS-1:0] cfg_data   // total_length
);
  import zsbf_pkg::*;

  logic [CFG_BITS-1:0]    total_length;
  logic [15:0]            sum_low;
  logic [15:0]            sum_high;
  logic [LENGTH_BITS-1:0] bytes_done;
  logic [BLOCK_BITS-1:0]  block_left;

  logic       in_valid;
  logic [7:0] in_byte;

  slot_mask_t mask;
  logic       buf_bfinal;
  logic [15:0] buf_len;
  logic [7:0] buf_byte;
  logic [15:0] buf_sum_high;
  logic [15:0] buf_sum_low;

  logic [LENGTH_BITS-1:0] total;
  logic [LENGTH_BITS-1:0] remaining;
  logic [LENGTH_BITS-1:0] bytes_next;
  logic [15:0]            len;
  logic                   final_block;
  logic                   open_stream;
  logic                   open_block;
  logic                   close_stream;
  logic [16:0]            low_sum;
  logic [16:0]            high_sum;
  logic [15:0]            sum_low_next;
  logic [15:0]            sum_high_next;
  logic [BLOCK_BITS-1:0]  block_left_next;
  slot_mask_t             mask_load;
  slot_mask_t             mask_rest;
  slot_t                  idx;
  logic                   one_left;
  logic                   load;

  assign cfg_ready = 1'b1;

  // framing of the registered input byte
  always_comb begin
    total = (total_length == '0) ? LENGTH_BITS'(1) : total_length;
    open_stream = (bytes_done == '0);
    open_block  = (block_left == '0);
    remaining = (total > bytes_done) ? (total - bytes_done) : LENGTH_BITS'(1);
    if (remaining < MAX_BLOCK_LEN) begin
      len = remaining[15:0];
    end else begin
      len = MAX_BLOCK_LEN[15:0];
    end
    final_block = (remaining <= MAX_BLOCK_LEN);

    low_sum = {1'b0, sum_low} + {9'd0, in_byte};
    if (low_sum >= ADLER_MOD) begin
      low_sum = low_sum - ADLER_MOD;
    end
    sum_low_next = low_sum[15:0];
    high_sum = {1'b0, sum_high} + {1'b0, sum_low_next};
    if (high_sum >= ADLER_MOD) begin
      high_sum = high_sum - ADLER_MOD;
    end
    sum_high_next = high_sum[15:0];

    bytes_next = bytes_done + LENGTH_BITS'(1);
    close_stream = (bytes_next >= total) || (bytes_next == '0);
    block_left_next = (open_block ? {1'b0, len} : block_left) - BLOCK_BITS'(1);

    mask_load = '0;
    mask_load[SLOT_CMF]     = open_stream;
    mask_load[SLOT_FLG]     = open_stream;
    mask_load[SLOT_BFINAL]  = open_block;
    mask_load[SLOT_LEN_LO]  = open_block;
    mask_load[SLOT_LEN_HI]  = open_block;
    mask_load[SLOT_NLEN_LO] = open_block;
    mask_load[SLOT_NLEN_HI] = open_block;
    mask_load[SLOT_DATA]    = 1'b1;
    mask_load[SLOT_SH_HI]   = close_stream;
    mask_load[SLOT_SH_LO]   = close_stream;
    mask_load[SLOT_SL_HI]   = close_stream;
    mask_load[SLOT_SL_LO]   = close_stream;
  end

  // output slot selection
  always_comb begin
    idx = SLOT_CMF;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = SLOT_BITS'(i);
      end
    end
    mask_rest = mask & (mask - slot_mask_t'(1));
    one_left  = (mask_rest == '0);
  end

  always_comb begin
    unique case (idx)
      SLOT_CMF:     m_tdata = ZLIB_CMF;
      SLOT_FLG:     m_tdata = ZLIB_FLG;
      SLOT_BFINAL:  m_tdata = {7'd0, buf_bfinal};
      SLOT_LEN_LO:  m_tdata = buf_len[7:0];
      SLOT_LEN_HI:  m_tdata = buf_len[15:8];
      SLOT_NLEN_LO: m_tdata = ~buf_len[7:0];
      SLOT_NLEN_HI: m_tdata = ~buf_len[15:8];
      SLOT_DATA:    m_tdata = buf_byte;
      SLOT_SH_HI:   m_tdata = buf_sum_high[15:8];
      SLOT_SH_LO:   m_tdata = buf_sum_high[7:0];
      SLOT_SL_HI:   m_tdata = buf_sum_low[15:8];
      SLOT_SL_LO:   m_tdata = buf_sum_low[7:0];
      default:      m_tdata = 8'h00;
    endcase
  end

  assign m_tvalid = (mask != '0);
  assign m_tlast  = one_left;
  assign m_tuser  = (idx == SLOT_SL_LO);

  assign load     = in_valid && ((mask == '0) || (one_left && m_tready));
  assign s_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= CFG_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      total_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask       <= '0;
      sum_low    <= 16'd1;
      sum_high   <= '0;
      bytes_done <= '0;
      block_left <= '0;
    end else if (load) begin
      mask <= mask_load;
      if (close_stream) begin
        sum_low    <= 16'd1;
        sum_high   <= '0;
        bytes_done <= '0;
        block_left <= '0;
      end else begin
        sum_low    <= sum_low_next;
        sum_high   <= sum_high_next;
        bytes_done <= bytes_next;
        block_left <= block_left_next;
      end
    end else if (m_tvalid && m_tready) begin
      mask <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_bfinal   <= final_block;
      buf_len      <= len;
      buf_byte     <= in_byte;
      buf_sum_high <= sum_high_next;
      buf_sum_low  <= sum_low_next;
    end
  end

endmodule

// ===== test/tb_top.sv =====
// testbench for zlib_stored_block_framer_core: payload bytes in, zlib stream bytes out
// predicts headers, stored block framing and adler-32 trailers and checks every output transfer
// depends on zsbf_pkg and the core rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned SINK_HOLD   = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fin;
  } zbyte_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = 8'h00;   // data_byte
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [7:0]                    m_tdata;           // out_byte
  logic                          m_tlast;           // run_last
  logic                          m_tuser;           // stream_end
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [zsbf_pkg::CFG_BITS-1:0] cfg_data = '0;     // total_length

  // predictor state
  logic [23:0] len_reg  = 24'd1;
  int unsigned adl_lo   = 1;
  int unsigned adl_hi   = 0;
  logic [23:0] pay_done = '0;
  logic [16:0] blk_left = '0;

  zbyte_t frame_q[$];
  zbyte_t run_q[$];

  int unsigned n_items   = 0;
  int unsigned n_results = 0;
  int unsigned n_streams = 0;
  int unsigned n_cfg     = 0;
  int unsigned errors    = 0;
  int unsigned idle_cnt  = 0;

  bit src_gaps_on  = 1'b1;
  bit sink_gaps_on = 1'b1;
  int unsigned sink_hold_req = 0;
  int unsigned hold_left     = 0;

  zlib_stored_block_framer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void stage_byte(input logic [7:0] v, input logic fin);
    zbyte_t e;
    e.data = v;
    e.last = 1'b0;
    e.fin  = fin;
    run_q = {run_q, e};
  endfunction

  // expected stream bytes for one payload byte
  function automatic void frame_byte(input logic [7:0] b);
    int unsigned total;
    int unsigned remaining;
    int unsigned blen;
    int unsigned nlen;
    zbyte_t e;
    total = 32'(len_reg);
    if (total == 0) total = 1;
    run_q.delete();
    if (pay_done == 0) begin
      stage_byte(zsbf_pkg::ZLIB_CMF, 1'b0);
      stage_byte(zsbf_pkg::ZLIB_FLG, 1'b0);
    end
    if (blk_left == 0) begin
      remaining = (total > pay_done) ? total - pay_done : 1;
      blen = (remaining < zsbf_pkg::MAX_BLOCK) ? remaining : zsbf_pkg::MAX_BLOCK;
      nlen = ~blen & 32'hFFFF;
      stage_byte((blen >= remaining) ? 8'd1 : 8'd0, 1'b0);
      stage_byte(8'(blen), 1'b0);
      stage_byte(8'(blen >> 8), 1'b0);
      stage_byte(8'(nlen), 1'b0);
      stage_byte(8'(nlen >> 8), 1'b0);
      blk_left = 17'(blen);
    end
    stage_byte(b, 1'b0);
    adl_lo   = (adl_lo + b) % zsbf_pkg::ADLER_MOD;
    adl_hi   = (adl_hi + adl_lo) % zsbf_pkg::ADLER_MOD;
    pay_done = pay_done + 24'd1;
    blk_left = blk_left - 17'd1;
    if (pay_done >= total || pay_done == 0) begin
      stage_byte(8'(adl_hi >> 8), 1'b0);
      stage_byte(8'(adl_hi), 1'b0);
      stage_byte(8'(adl_lo >> 8), 1'b0);
      stage_byte(8'(adl_lo), 1'b1);
      adl_lo    = 1;
      adl_hi    = 0;
      pay_done  = '0;
      blk_left  = '0;
      n_streams = n_streams + 1;
    end
    foreach (run_q[i]) begin
      e = run_q[i];
      e.last = (i == run_q.size() - 1);
      frame_q = {frame_q, e};
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      frame_byte(s_tdata);
      n_items = n_items + 1;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      len_reg = cfg_data;
      n_cfg   = n_cfg + 1;
    end
  end

  always @(posedge clk) begin
    zbyte_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_results = n_results + 1;
      if (frame_q.size() == 0) begin
        errors = errors + 1;
        $display("%0t: expected no transfer, got data=%02h last=%0b end=%0b",
                 $time, m_tdata, m_tlast, m_tuser);
      end else begin
        e = frame_q.pop_front();
        if (m_tdata !== e.data || m_tlast !== e.last || m_tuser !== e.fin) begin
          errors = errors + 1;
          $display("%0t: expected data=%02h last=%0b end=%0b, got data=%02h last=%0b end=%0b",
                   $time, e.data, e.last, e.fin, m_tdata, m_tlast, m_tuser);
        end
      end
    end
  end

  // output ready: random stalls, or a long hold when requested
  always @(negedge clk) begin
    if (sink_hold_req > 0) begin
      hold_left     = sink_hold_req;
      sink_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !sink_gaps_on || ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt = idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cnt);
        $display("zlib_stored_block_framer_core: mismatch");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (src_gaps_on && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (frame_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_length(input logic [23:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_length();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_zero_length();
    write_length(24'd0);
    send_byte(8'hA5);
    send_byte(8'h5A);
  endtask

  task automatic test_short_streams();
    write_length(24'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h01);
    send_byte(8'h80);
  endtask

  task automatic test_length_change();
    write_length(24'd6);
    send_random(4);
    write_length(24'd2);
    send_byte(8'hFE);
    write_length(24'd4);
    send_random(2);
    write_length(24'd5);
    send_random(3);
  endtask

  task automatic test_backpressure();
    write_length(24'd7);
    sink_hold_req = SINK_HOLD;
    send_random(21);
    wait_drained();
    send_random(7);
  endtask

  task automatic test_random_streams();
    int unsigned sent;
    int unsigned len;
    int unsigned n;
    int unsigned k;
    sent = 0;
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    while (sent < 54) begin
      if (sent >= 30) begin
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
      end
      len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      write_length(24'(len));
      n = (len == 0) ? 1 : len;
      if (n > 1 && $urandom_range(4) == 0) begin
        // length rewritten partway through the stream
        k = $urandom_range(1, n - 1);
        send_random(k);
        sent = sent + k;
        write_length(24'($urandom_range(0, n + 4)));
        do begin
          send_byte(8'($urandom_range(255)));
          sent = sent + 1;
        end while (pay_done != 0);
      end else begin
        send_random(n);
        sent = sent + n;
      end
    end
  endtask

  // long lengths open a non-final full-size block, a shorter length then ends the stream
  task automatic test_block_split();
    write_length(24'd65540);
    send_random(3);
    write_length(24'd2);
    send_byte(8'h3C);
    write_length(24'hFFFFFF);
    send_random(3);
    write_length(24'd2);
    send_byte(8'hC3);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_length();
    test_zero_length();
    test_short_streams();
    test_length_change();
    test_backpressure();
    test_random_streams();
    test_block_split();
    wait_drained();
    repeat (20) @(posedge clk);
    if (frame_q.size() != 0) begin
      errors = errors + 1;
      $display("%0t: %0d expected transfers never arrived", $time, frame_q.size());
    end
    $display("run covered %0d payload bytes, %0d stream bytes, %0d streams, %0d length writes",
             n_items, n_results, n_streams, n_cfg);
    if (errors == 0) begin
      $display("zlib_stored_block_framer_core: match");
    end else begin
      $display("zlib_stored_block_framer_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/zsbf_pkg.sv
rtl/core/zlib_stored_block_framer_core.sv
test/tb_top.sv
